### rtl/core/vbi_pkg.sv
// Shared types, widths and status codes for the variable byte integer codec.
package vbi_pkg;

	// Field widths
	localparam int VALUE_W    = 32;
	localparam int DEC_W      = 28;
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int GROUP_BITS = 7;
	localparam int GROUP_CNT_W = 3;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Action codes
	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_ENC_BYTE  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PENDING   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd4;

	// Continuation flag and group mask of one encoded byte
	localparam logic [BYTE_W-1:0] CONT_BIT   = 8'h80;
	localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7f;

	// One classified item: what the back end has to emit for it.
	typedef struct packed {
		logic [STATUS_W-1:0] status;     // kind of result(s)
		logic [DEC_W-1:0]    value;      // value to encode or decoded value
		logic [1:0]          last_idx;   // index of the final result byte
	} vbi_desc_t;

endpackage

### rtl/core/vbi_front.sv
// Front end: accepts items, keeps the decoder state and classifies each item.
module vbi_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [vbi_pkg::VALUE_W-1:0] value_in,
	input  logic [vbi_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        q_full,
	output logic                        push,
	output vbi_pkg::vbi_desc_t          desc
);
	import vbi_pkg::*;

	logic [DEC_W-1:0]       acc_q;
	logic [GROUP_CNT_W-1:0] gcnt_q;
	logic [DEC_W-1:0]       grp_shifted;
	logic [DEC_W-1:0]       acc_next;
	logic [DEC_W-1:0]       grp_ext;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;
	assign grp_ext  = DEC_W'(data_byte & GROUP_MASK);

	// Place the new 7-bit group at the running shift.
	always_comb begin
		unique case (gcnt_q[1:0])
			2'd0:    grp_shifted = grp_ext;
			2'd1:    grp_shifted = grp_ext << GROUP_BITS;
			2'd2:    grp_shifted = grp_ext << (2 * GROUP_BITS);
			default: grp_shifted = grp_ext << (3 * GROUP_BITS);
		endcase
	end

	assign acc_next = acc_q | grp_shifted;

	// Classify the item into one descriptor for the back end.
	always_comb begin
		desc = '0;
		if (action == ACT_ENCODE) begin
			if (value_in[VALUE_W-1:DEC_W] != '0) begin
				desc.status = ST_TOO_LARGE;
			end else begin
				desc.status = ST_ENC_BYTE;
				desc.value  = value_in[DEC_W-1:0];
				priority if (value_in[27:21] != '0) begin
					desc.last_idx = 2'd3;
				end else if (value_in[20:14] != '0) begin
					desc.last_idx = 2'd2;
				end else if (value_in[13:7] != '0) begin
					desc.last_idx = 2'd1;
				end else begin
					desc.last_idx = 2'd0;
				end
			end
		end else begin
			if (gcnt_q[2]) begin
				desc.status = ST_TOO_MANY;
			end else begin
				desc.value  = acc_next;
				desc.status = (data_byte[BYTE_W-1]) ? ST_PENDING : ST_COMPLETE;
			end
		end
	end

	// Decoder state advances on each accepted decode item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			gcnt_q <= '0;
		end else if (push && action == ACT_DECODE) begin
			if (gcnt_q[2] || !data_byte[BYTE_W-1]) begin
				acc_q  <= '0;
				gcnt_q <= '0;
			end else begin
				acc_q  <= acc_next;
				gcnt_q <= gcnt_q + GROUP_CNT_W'(1);
			end
		end
	end

endmodule

### rtl/core/vbi_queue.sv
// Short queue of classified items between the front and back ends.
module vbi_queue #(
	parameter int DEPTH = vbi_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  vbi_pkg::vbi_desc_t wr_desc,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output vbi_pkg::vbi_desc_t rd_desc
);
	import vbi_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	vbi_desc_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_desc   = entry_q[rd_ptr_q];

	// Storage write
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/core/vbi_back.sv
// Back end: expands each queued item into its result items and holds the output register.
module vbi_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_not_empty,
	input  vbi_pkg::vbi_desc_t           head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [vbi_pkg::BYTE_W-1:0]   out_byte,
	output logic                         last,
	output logic [vbi_pkg::DEC_W-1:0]    decoded_value,
	output logic [vbi_pkg::STATUS_W-1:0] status
);
	import vbi_pkg::*;

	logic [1:0]          idx_q;
	logic                valid_q;
	logic [BYTE_W-1:0]   byte_q;
	logic                last_q;
	logic [DEC_W-1:0]    dec_q;
	logic [STATUS_W-1:0] status_q;
	logic                load;
	logic                is_last;
	logic                is_enc;
	logic [GROUP_BITS-1:0] grp;

	assign load    = q_not_empty && (!valid_q || out_ready);
	assign is_last = (idx_q == head.last_idx);
	assign is_enc  = (head.status == ST_ENC_BYTE);
	assign pop     = load && is_last;

	// Select the 7-bit group for the current result byte.
	always_comb begin
		unique case (idx_q)
			2'd0:    grp = head.value[6:0];
			2'd1:    grp = head.value[13:7];
			2'd2:    grp = head.value[20:14];
			default: grp = head.value[27:21];
		endcase
	end

	// Byte index within the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			last_q   <= is_last;
			status_q <= head.status;
			if (is_enc) begin
				byte_q <= {!is_last, grp};
				dec_q  <= '0;
			end else begin
				byte_q <= '0;
				dec_q  <= head.value;
			end
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign last          = last_q;
	assign decoded_value = dec_q;
	assign status        = status_q;

endmodule

### rtl/core/variable_byte_integer_codec.sv
// Top level of the variable byte integer codec: front end, queue and back end.
//
// Streaming codec for variable byte integers. Each input item either encodes
// value_in (s_tuser low) into one to four bytes, least significant group first,
// or decodes one data_byte (s_tuser high) into a pending or complete result.
// The input side takes one item per cycle while the queue has room; the decoder
// state sits in the front end and updates in the cycle an item is accepted.
// Results leave through a registered output at one result per cycle while
// m_tready is high, so a decode item yields one result and an encode item as
// many results as it has bytes (1 to 4); the output port is the limit on
// sustained rate. A queue of QUEUE_DEPTH entries lets the input keep running
// while a multi-byte encode drains. With the queue empty, an accepted item is
// written into the queue, then loaded into the output register for m_tvalid.
module variable_byte_integer_codec #(
	parameter int QUEUE_DEPTH = vbi_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value_in[31:0], data_byte[39:32]
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_byte[7:0], decoded_value[35:8], zero[39:36]
	output logic        m_tlast,   // last
	output logic [2:0]  m_tuser    // status
);
	import vbi_pkg::*;

	vbi_desc_t           push_desc;
	vbi_desc_t           head_desc;
	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_not_empty;
	logic [BYTE_W-1:0]   out_byte;
	logic [DEC_W-1:0]    decoded_value;

	vbi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.action    (s_tuser),
		.value_in  (s_tdata[31:0]),
		.data_byte (s_tdata[39:32]),
		.q_full    (q_full),
		.push      (push),
		.desc      (push_desc)
	);

	vbi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_desc   (push_desc),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.rd_desc   (head_desc)
	);

	vbi_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.head          (head_desc),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_byte      (out_byte),
		.last          (m_tlast),
		.decoded_value (decoded_value),
		.status        (m_tuser)
	);

	assign m_tdata = {4'b0000, decoded_value, out_byte};

	// The queue is never written while full.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue written while full");

	// Every encoded byte but the final one carries the continuation bit.
	a_enc_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_ENC_BYTE && !m_tlast) |-> m_tdata[7])
		else $error("non-final encoded byte without continuation bit");

	// Results other than encoded bytes are single and carry no byte.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_ENC_BYTE) |-> (m_tlast && m_tdata[7:0] == '0))
		else $error("non-encode result not final or has a byte");

	// The queue is only popped when it holds an entry.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty)
		else $error("queue popped while empty");

endmodule
